@@ hw/rtl/hkl_pkg.sv @@
// Shared types, constants and hash helpers for the hashed key lookup-or-insert block.
// No dependencies; every other file imports this package.
package hkl_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 16;
	localparam int unsigned HASH_STAGES     = 8;
	// power of two, so the queue pointers wrap on their own
	localparam int unsigned QUEUE_DEPTH     = 2;
	localparam int unsigned SLOT_W          = 4;

	localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME  = 32'd16777619;

	typedef struct packed {
		logic [31:0] features;
		logic [1:0]  quality;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              hit;
		logic              full_res;
		logic [31:0]       key_hash;
	} res_t;

	// request after hashing, as queued between front and back
	typedef struct packed {
		logic [31:0] features;
		logic [1:0]  quality;
		logic [31:0] key_hash;
	} key_t;

	// one FNV-1a byte step: xor, then multiply by the prime modulo 2^32
	function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		x = h ^ {24'd0, b};
		return x * FNV_PRIME;
	endfunction

	// key byte idx: features LSB first, then quality widened to 32 bits
	function automatic logic [7:0] key_byte(input logic [31:0] features,
			input logic [1:0] quality, input int unsigned idx);
		logic [63:0] w;
		w = {30'd0, quality, features};
		return w[8*idx +: 8];
	endfunction

endpackage

@@ hw/rtl/hkl_stream_ifs.sv @@
// Valid/ready stream interfaces for requests, hashed keys and results.
// Depends on hkl_pkg for the payload types.
interface hkl_req_if;
	import hkl_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hkl_key_if;
	import hkl_pkg::*;
	logic valid;
	logic ready;
	key_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hkl_res_if;
	import hkl_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/hkl_hash.sv @@
// Front end: eight-stage FNV-1a pipeline, one key byte and one multiply per stage.
// Depends on hkl_pkg and the stream interfaces.
module hkl_hash
	import hkl_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	hkl_req_if.sink   req,
	hkl_key_if.source key
);

	// stage arrays, entry k holds the state after key byte k
	logic        pipe_valid_s [HASH_STAGES];
	logic [31:0] pipe_hash_s  [HASH_STAGES];
	req_t        pipe_req_s   [HASH_STAGES];
	logic        advance;

	// whole pipe moves together; it only stops when the last stage cannot leave
	assign advance   = !pipe_valid_s[HASH_STAGES-1] || key.ready;
	assign req.ready = advance;

	assign key.valid         = pipe_valid_s[HASH_STAGES-1];
	assign key.data.features = pipe_req_s[HASH_STAGES-1].features;
	assign key.data.quality  = pipe_req_s[HASH_STAGES-1].quality;
	assign key.data.key_hash = pipe_hash_s[HASH_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < HASH_STAGES; k++) begin
				pipe_valid_s[k] <= 1'b0;
			end
		end else if (advance) begin
			pipe_valid_s[0] <= req.valid;
			for (int k = 1; k < HASH_STAGES; k++) begin
				pipe_valid_s[k] <= pipe_valid_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pipe_req_s[0]  <= req.data;
			pipe_hash_s[0] <= fnv_step(FNV_OFFSET,
				key_byte(req.data.features, req.data.quality, 0));
		end
	end

	for (genvar k = 1; k < HASH_STAGES; k++) begin : g_stage
		always_ff @(posedge clk) begin
			if (advance) begin
				pipe_req_s[k]  <= pipe_req_s[k-1];
				pipe_hash_s[k] <= fnv_step(pipe_hash_s[k-1],
					key_byte(pipe_req_s[k-1].features, pipe_req_s[k-1].quality, k));
			end
		end
	end

endmodule

@@ hw/rtl/hkl_queue.sv @@
// Short queue of hashed keys between the hash front end and the table back end.
// Depends on hkl_pkg and the stream interfaces.
module hkl_queue
	import hkl_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	hkl_key_if.sink   wr,
	hkl_key_if.source rd
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(QUEUE_DEPTH);

	key_t             buf_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign wr.ready = (count_q != CNT_MAX);
	assign rd.valid = (count_q != '0);
	assign rd.data  = buf_q[rd_ptr_q];
	assign push     = wr.valid && wr.ready;
	assign pop      = rd.valid && rd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= wr.data;
		end
	end

endmodule

@@ hw/rtl/hkl_table.sv @@
// Back end: key store with one comparator per entry, match resolve, append and result register.
// Depends on hkl_pkg and the stream interfaces.
module hkl_table
	import hkl_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	hkl_key_if.sink   key,
	hkl_res_if.source res
);

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

	localparam logic ST_LOOKUP  = 1'b0;
	localparam logic ST_RESOLVE = 1'b1;

	logic                   state_q;
	logic [CNT_W-1:0]       count_q;
	logic [31:0]            tbl_hash_q [TABLE_DEPTH];
	logic [31:0]            tbl_feat_q [TABLE_DEPTH];
	logic [1:0]             tbl_qual_q [TABLE_DEPTH];
	key_t                   key_q;
	logic [TABLE_DEPTH-1:0] match;
	logic [TABLE_DEPTH-1:0] match_q;
	res_t                   res_q;
	logic                   res_valid_q;

	logic             hit;
	logic             full;
	logic [IDX_W-1:0] hit_idx;
	logic [IDX_W-1:0] ins_idx;
	logic [IDX_W-1:0] slot_idx;
	logic             load;
	logic             insert;

	// only entries below the fill count are live
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cmp
		assign match[i] = (CNT_W'(i) < count_q)
			&& (tbl_hash_q[i] == key.data.key_hash)
			&& (tbl_feat_q[i] == key.data.features)
			&& (tbl_qual_q[i] == key.data.quality);
	end

	// keys are only appended on a miss, so at most one entry can match
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (match_q[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
	end

	assign hit      = |match_q;
	assign full     = !hit && (count_q == CNT_FULL);
	assign ins_idx  = count_q[IDX_W-1:0];
	assign slot_idx = hit ? hit_idx : (full ? '0 : ins_idx);
	assign load     = (state_q == ST_RESOLVE) && (!res_valid_q || res.ready);
	assign insert   = load && !hit && !full;

	assign key.ready = (state_q == ST_LOOKUP);
	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOOKUP;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOOKUP: begin
					if (key.valid) begin
						state_q <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					if (load) begin
						state_q <= ST_LOOKUP;
					end
				end
				default: begin
					state_q <= ST_LOOKUP;
				end
			endcase
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (insert) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (key.valid && key.ready) begin
			key_q   <= key.data;
			match_q <= match;
		end
		if (load) begin
			res_q.slot     <= SLOT_W'(slot_idx);
			res_q.hit      <= hit;
			res_q.full_res <= full;
			res_q.key_hash <= key_q.key_hash;
		end
		if (insert) begin
			tbl_hash_q[ins_idx] <= key_q.key_hash;
			tbl_feat_q[ins_idx] <= key_q.features;
			tbl_qual_q[ins_idx] <= key_q.quality;
		end
	end

endmodule

@@ hw/rtl/hashed_key_lookup_or_insert_top.sv @@
// Top level of the hashed key lookup-or-insert block.
// Depends on hkl_pkg, the stream interfaces, hkl_hash, hkl_queue and hkl_table.

// Each request (feature mask, quality) is hashed with 32-bit FNV-1a over eight bytes in an
// eight-stage pipeline, queued, then looked up against up to TABLE_DEPTH stored keys; a miss
// appends the key and returns its slot, a miss on a full table returns full_res with slot 0.
// The back end compares all entries, then resolves and appends, and takes no new request
// until the current one is resolved; resolve waits while the result register is full and
// not being read. A request passes the 8 hash stages, the first loaded at acceptance, then
// the queue and the compare and resolve states of the table before the result register.
// Results wait in an output register while the next request is already being worked on.
// The table needs no clearing after reset: unfilled entries are never compared.
module hashed_key_lookup_or_insert_top
	import hkl_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	hkl_req_if.sink   req,
	hkl_res_if.source res
);

	hkl_key_if hashed ();
	hkl_key_if queued ();

	hkl_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.key    (hashed)
	);

	hkl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (hashed),
		.rd     (queued)
	);

	hkl_table #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (queued),
		.res    (res)
	);

endmodule
